// File: src/bmpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_pkg
// shared constants and types for the binomial mod prime table block
// ----------------------------------------------------------------------------
package bmpt_pkg;
   localparam int unsigned TableSizeDefault = 262144;
   localparam int unsigned ValueWidth = 30;
   localparam logic [29:0] PrimeMod = 30'd1000000007;
   // exponent for the inverse, p - 2
   localparam logic [29:0] PrimeExp = 30'd1000000005;
   // cycles from operands in to product out of the modular multiplier
   localparam int unsigned MulLatency = 6;

   typedef logic [ValueWidth-1:0] residue_type;
endpackage
`default_nettype wire

// File: src/binomial_mod_prime_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_mod_prime_table
// n choose r mod 1000000007 from factorial and inverse factorial memories
// ----------------------------------------------------------------------------
// channel | ports                                   | direction
// req     | req_valid req_ready req_top_count       | in
//         | req_choose_count                        |
// rsp     | rsp_valid rsp_ready rsp_coefficient     | out
//         | rsp_range_error                         |
// after reset the tables are built: forward, each entry is written and then
// passed through the multiplier; a 30 bit exponentiation squares for every
// bit and multiplies when the bit is set; then backwards, each entry is
// written and then multiplied by its index; req_ready is low until then.
// queries then run one per cycle while req_ready is high, through a read
// stage and two chained multipliers. a 32 entry result queue absorbs stalls,
// req_ready drops once 31 beats are in flight.
// ----------------------------------------------------------------------------
module binomial_mod_prime_table #(
   parameter int unsigned TABLE_SIZE = bmpt_pkg::TableSizeDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [17:0] req_top_count,
   input  wire  [18:0] req_choose_count,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [29:0] rsp_coefficient,
   output logic        rsp_range_error
);
   localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int unsigned CW = AW + 1;
   localparam int unsigned MulLat = bmpt_pkg::MulLatency;
   localparam int unsigned QDepth = 32;
   localparam int unsigned QAW = 5;

   localparam logic [2:0] StFwd  = 3'd0;
   localparam logic [2:0] StPow  = 3'd1;
   localparam logic [2:0] StBwd  = 3'd2;
   localparam logic [2:0] StRun  = 3'd3;
   localparam logic [2:0] StWait = 3'd4;

   bmpt_pkg::residue_type fact_mem [TABLE_SIZE];
   bmpt_pkg::residue_type inv_mem  [TABLE_SIZE];

   logic [2:0]  state_ff, state_in;
   logic [2:0]  ret_ff, ret_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0]  wait_ff, wait_in;
   bmpt_pkg::residue_type acc_ff, acc_in, base_ff, base_in;
   logic [4:0]  ebit_ff, ebit_in;
   logic        phase_ff, phase_in;

   // shared multiplier
   logic                  m_valid, m_ovalid;
   bmpt_pkg::residue_type m_a, m_b, m_p;
   bmpt_modmul u_mul (
      .clock(clock), .reset(reset), .in_valid(m_valid), .in_a(m_a), .in_b(m_b),
      .out_valid(m_ovalid), .out_p(m_p)
   );

   // query pipeline
   logic        accept;
   logic [AW-1:0] ra_n, ra_r, ra_d;
   bmpt_pkg::residue_type rd_f_ff, rd_r_ff, rd_d_ff, rd_d2_ff [MulLat];
   logic [18:0] diff;
   logic        n_bad, r_bad;

   // build time memory access
   logic        f_we, i_we;
   logic [AW-1:0] w_addr;
   bmpt_pkg::residue_type w_data;

   assign n_bad = ({14'd0, req_top_count} >= 32'(TABLE_SIZE));
   assign diff  = {1'b0, req_top_count} - req_choose_count;
   assign r_bad = req_choose_count[18] | diff[18];
   assign ra_n  = AW'(req_top_count);
   assign ra_r  = AW'(req_choose_count);
   assign ra_d  = AW'(diff);

   always_ff @(posedge clock) begin
      if (f_we) fact_mem[w_addr] <= w_data;
      if (i_we) inv_mem[w_addr]  <= w_data;
      rd_f_ff <= fact_mem[ra_n];
      rd_r_ff <= inv_mem[ra_r];
      rd_d_ff <= inv_mem[ra_d];
   end

   // stage 2 operand delay for invfact[n-r]
   always_ff @(posedge clock) begin
      rd_d2_ff[0] <= rd_d_ff;
      for (int k = 1; k < MulLat; k++) rd_d2_ff[k] <= rd_d2_ff[k-1];
   end

   // result queue
   logic [30:0] q_data [QDepth];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff, infl_ff;
   logic           pop;

   // query path: memories read, mul1, then mul2
   logic          s1_v, s2_v;
   logic          vq_ff;
   logic [2*MulLat:0] zq_ff, eq_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else begin
         vq_ff <= accept;
      end
      zq_ff <= {zq_ff[2*MulLat-1:0], n_bad | r_bad};
      eq_ff <= {eq_ff[2*MulLat-1:0], n_bad};
   end
   assign s1_v = (state_ff == StRun) & vq_ff;
   assign s2_v = (state_ff == StRun) & m_ovalid;

   // second product on its own multiplier so queries run one per cycle while req_ready is high
   logic                  m2_ovalid;
   bmpt_pkg::residue_type m2_p;
   bmpt_modmul u_mul2 (
      .clock(clock), .reset(reset), .in_valid(s2_v), .in_a(m_p),
      .in_b(rd_d2_ff[MulLat-1]), .out_valid(m2_ovalid), .out_p(m2_p)
   );

   logic bld_mul_v;
   bmpt_pkg::residue_type bld_a, bld_b;
   assign m_valid = (state_ff == StRun) ? s1_v : bld_mul_v;
   assign m_a     = (state_ff == StRun) ? rd_f_ff : bld_a;
   assign m_b     = (state_ff == StRun) ? rd_r_ff : bld_b;

   // queue push at end of second product
   logic push;
   logic [30:0] push_d;
   assign push   = m2_ovalid;
   assign push_d = {eq_ff[2*MulLat], zq_ff[2*MulLat] ? 30'd0 : m2_p};
   assign pop    = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (push) q_data[wp_ff] <= push_d;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; infl_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff  <= cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
         infl_ff <= infl_ff + (QAW+1)'(accept) - (QAW+1)'(pop);
      end
   end

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_coefficient = q_data[rp_ff][29:0];
   assign rsp_range_error = q_data[rp_ff][30];
   assign req_ready = (state_ff == StRun) & (infl_ff < (QAW+1)'(QDepth - 1));
   assign accept    = req_valid & req_ready;

   // build sequencer
   logic [AW-1:0] idx_a;
   assign idx_a = idx_ff[AW-1:0];

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; idx_in = idx_ff; wait_in = wait_ff;
      acc_in = acc_ff; base_in = base_ff; ebit_in = ebit_ff; phase_in = phase_ff;
      bld_mul_v = 1'b0; bld_a = acc_ff; bld_b = base_ff;
      f_we = 1'b0; i_we = 1'b0; w_addr = idx_a; w_data = acc_ff;
      unique case (state_ff)
         StFwd: begin
            // acc holds (idx)!; write it, then multiply by idx+1
            if (!phase_ff) begin
               f_we = 1'b1;
               if (idx_ff == CW'(TABLE_SIZE - 1)) begin
                  base_in = acc_ff; acc_in = 30'd1; ebit_in = 5'd29;
                  state_in = StPow; phase_in = 1'b0;
               end else begin
                  bld_mul_v = 1'b1; bld_b = 30'(idx_ff + 1'b1);
                  phase_in = 1'b1; wait_in = 5'(MulLat - 1);
                  ret_in = StFwd; state_in = StWait;
               end
            end else begin
               acc_in = m_p; idx_in = idx_ff + 1'b1; phase_in = 1'b0;
            end
         end
         StPow: begin
            // left to right: square, then multiply if bit set
            if (!phase_ff) begin
               bld_mul_v = 1'b1; bld_a = acc_ff; bld_b = acc_ff;
               phase_in = 1'b1; wait_in = 5'(MulLat - 1);
               ret_in = StPow; state_in = StWait;
            end else begin
               if (bmpt_pkg::PrimeExp[ebit_ff] && !wait_ff[4]) begin
                  bld_mul_v = 1'b1; bld_a = m_p; bld_b = base_ff;
                  wait_in = 5'(MulLat - 1) | 5'h10;
                  ret_in = StPow; state_in = StWait;
               end else begin
                  acc_in = m_p; phase_in = 1'b0; wait_in = '0;
                  if (ebit_ff == 5'd0) begin
                     state_in = StBwd;
                  end else begin
                     ebit_in = ebit_ff - 1'b1;
                  end
               end
            end
         end
         StBwd: begin
            // acc holds invfact[idx]; write it, then multiply by idx
            if (!phase_ff) begin
               i_we = 1'b1;
               if (idx_ff == '0) begin
                  state_in = StRun;
               end else begin
                  bld_mul_v = 1'b1; bld_b = 30'(idx_ff);
                  phase_in = 1'b1; wait_in = 5'(MulLat - 1);
                  ret_in = StBwd; state_in = StWait;
               end
            end else begin
               acc_in = m_p; idx_in = idx_ff - 1'b1; phase_in = 1'b0;
            end
         end
         StWait: begin
            if (wait_ff[3:0] == 4'd1) begin
               state_in = ret_ff;
               wait_in = {wait_ff[4], 4'd0};
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         StRun: ;
         default: state_in = StFwd;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StFwd; idx_ff <= '0; acc_ff <= 30'd1; phase_ff <= 1'b0;
         wait_ff <= '0; ret_ff <= StFwd; ebit_ff <= '0; base_ff <= '0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; acc_ff <= acc_in;
         phase_ff <= phase_in; wait_ff <= wait_in; ret_ff <= ret_in;
         ebit_ff <= ebit_in; base_ff <= base_in;
      end
   end
endmodule
`default_nettype wire

// File: src/bmpt_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_modmul
// pipelined multiply modulo 1000000007: 30x30 product, then a barrett style
// reduction over registered stages, one operand pair per cycle
// ----------------------------------------------------------------------------
module bmpt_modmul (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire  bmpt_pkg::residue_type in_a,
   input  wire  bmpt_pkg::residue_type in_b,
   output logic                       out_valid,
   output bmpt_pkg::residue_type      out_p
);
   // mu = floor(2^60 / p), 31 bits
   localparam logic [30:0] Mu = 31'd1152921496;
   localparam int unsigned Lat = bmpt_pkg::MulLatency;

   logic [Lat-1:0] vld_ff;
   logic [59:0] prod_ff;
   logic [31:0] plo2_ff, plo3_ff, plo4_ff;
   logic [30:0] qhi_ff;
   logic [30:0] q_ff, q_in;
   logic [31:0] qp_ff, qp_in;
   logic [31:0] rem_ff;
   bmpt_pkg::residue_type res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Lat-2:0], in_valid};
      end
   end

   assign q_in  = 31'(({31'd0, qhi_ff} * {31'd0, Mu}) >> 31);
   // remainder below 3p fits 32 bits, so only the low words are carried
   assign qp_in = 32'({31'd0, q_ff} * {32'd0, bmpt_pkg::PrimeMod});

   always_ff @(posedge clock) begin
      prod_ff <= {30'd0, in_a} * {30'd0, in_b};
      qhi_ff  <= prod_ff[59:29];
      plo2_ff <= prod_ff[31:0];
      q_ff    <= q_in;
      plo3_ff <= plo2_ff;
      qp_ff   <= qp_in;
      plo4_ff <= plo3_ff;
      rem_ff  <= plo4_ff - qp_ff;
      if (rem_ff >= {1'b0, bmpt_pkg::PrimeMod, 1'b0})
         res_ff <= 30'(rem_ff - {1'b0, bmpt_pkg::PrimeMod, 1'b0});
      else if (rem_ff >= {2'd0, bmpt_pkg::PrimeMod})
         res_ff <= 30'(rem_ff - {2'd0, bmpt_pkg::PrimeMod});
      else
         res_ff <= rem_ff[29:0];
   end

   assign out_valid = vld_ff[Lat-1];
   assign out_p     = res_ff;
endmodule
`default_nettype wire

// File: tb/sv/tb_binomial_mod_prime_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_table
// Drives (n, r) queries into the block and checks each C(n,r) mod p answer
// against factorial tables computed in the bench, or against the values listed
// in the typed directed rows. Directed rows cover the extremes and the
// zero-result cases. Random queries follow, with random gaps on both sides,
// one long receiver stall and one full drain.
module tb_binomial_mod_prime_table;
   localparam int unsigned Depth = bmpt_pkg::TableSizeDefault;
   localparam longint unsigned Prime = 64'd1000000007;
   localparam int RandomQueries = 2000;
   localparam int DrainAt = 900;
   localparam int StallAt = 400;

   typedef struct {
      logic [29:0] coefficient;
      logic        range_error;
   } answer_type;

   typedef struct {
      logic [17:0] top;
      logic [18:0] choose;
      logic        typed;
      logic [29:0] coefficient;
   } query_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [17:0] req_top_count = '0;
   logic [18:0] req_choose_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [29:0] rsp_coefficient;
   logic        rsp_range_error;

   logic [29:0] fact_mem [0:Depth-1];
   logic [29:0] inv_fact_mem [0:Depth-1];
   answer_type  pending_answers [$];
   int          mismatches = 0;
   int          answers_seen = 0;
   int          queries_sent = 0;
   bit          sender_done = 1'b0;

   binomial_mod_prime_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_top_count(req_top_count), .req_choose_count(req_choose_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_coefficient(rsp_coefficient), .rsp_range_error(rsp_range_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #400ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [29:0] mul_mod(logic [29:0] a, logic [29:0] b);
      longint unsigned prod;
      prod = longint'(a) * longint'(b);
      return 30'(prod % Prime);
   endfunction

   function automatic void build_factorials();
      logic [29:0] acc;
      logic [29:0] base;
      longint unsigned expo;
      fact_mem[0] = 30'd1;
      for (int i = 1; i < Depth; i++) begin
         fact_mem[i] = mul_mod(fact_mem[i-1], 30'(i));
      end
      // inverse of the last factorial by Fermat, the rest walking down
      acc = 30'd1;
      base = fact_mem[Depth-1];
      expo = Prime - 2;
      while (expo != 0) begin
         if (expo[0]) begin
            acc = mul_mod(acc, base);
         end
         base = mul_mod(base, base);
         expo = expo >> 1;
      end
      inv_fact_mem[Depth-1] = acc;
      for (int i = Depth - 1; i > 0; i--) begin
         inv_fact_mem[i-1] = mul_mod(inv_fact_mem[i], 30'(i));
      end
   endfunction

   function automatic answer_type binomial_of(logic [17:0] top, logic [18:0] choose);
      answer_type ans;
      int r;
      r = $signed(choose);
      ans.coefficient = '0;
      ans.range_error = 1'b0;
      if (int'(top) >= Depth) begin
         ans.range_error = 1'b1;
      end else if (r >= 0 && r <= int'(top)) begin
         ans.coefficient = mul_mod(mul_mod(fact_mem[top], inv_fact_mem[r]),
                                   inv_fact_mem[int'(top) - r]);
      end
      return ans;
   endfunction

   // one beat on the query side; the expectation is queued on acceptance
   task automatic send_query(logic [17:0] top, logic [18:0] choose, answer_type ans);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (queries_sent % 300 < 60) begin
         gap = 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_top_count <= top;
      req_choose_count <= choose;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      pending_answers.push_back(ans);
      queries_sent++;
   endtask

   initial begin
      query_row_type rows [$];
      logic [17:0] top;
      logic [18:0] choose;
      answer_type ans;
      int sel;

      build_factorials();
      rows = '{
         '{18'd0, 19'd0, 1'b1, 30'd1},
         '{18'd0, 19'd1, 1'b1, 30'd0},
         '{18'd1, 19'd1, 1'b1, 30'd1},
         '{18'd5, 19'd5, 1'b1, 30'd1},
         '{18'd5, 19'd6, 1'b1, 30'd0},
         '{18'd5, 19'h7FFFF, 1'b1, 30'd0},
         '{18'd10, 19'd3, 1'b1, 30'd120},
         '{18'd20, 19'd10, 1'b1, 30'd184756},
         '{18'h3FFFF, 19'd0, 1'b1, 30'd1},
         '{18'h3FFFF, 19'd1, 1'b1, 30'd262143},
         '{18'h3FFFF, 19'h3FFFE, 1'b1, 30'd262143},
         '{18'h3FFFF, 19'h3FFFF, 1'b1, 30'd1},
         '{18'h3FFFF, 19'h40000, 1'b1, 30'd0},
         '{18'd0, 19'h3FFFF, 1'b1, 30'd0},
         '{18'd0, 19'h40000, 1'b1, 30'd0},
         '{18'h3FFFF, 19'h1FFFF, 1'b0, 30'd0},
         '{18'h20000, 19'h10000, 1'b0, 30'd0},
         '{18'd100000, 19'd33333, 1'b0, 30'd0},
         '{18'd12, 19'd6, 1'b0, 30'd0},
         '{18'd131071, 19'd1, 1'b0, 30'd0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         ans = binomial_of(rows[i].top, rows[i].choose);
         if (rows[i].typed) begin
            ans.coefficient = rows[i].coefficient;
            ans.range_error = 1'b0;
         end
         send_query(rows[i].top, rows[i].choose, ans);
      end

      for (int k = 0; k < RandomQueries; k++) begin
         if (k == DrainAt) begin
            req_valid <= 1'b0;
            while (pending_answers.size() != 0) @(posedge clock);
         end
         top = ($urandom_range(0, 3) == 0) ? 18'($urandom_range(0, 40)) : 18'($urandom);
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            choose = 19'($urandom_range(0, top));
         end else if (sel < 8) begin
            choose = 19'($urandom_range(top, 262143));
         end else if (sel < 9) begin
            choose = 19'(-$urandom_range(1, 262144));
         end else begin
            choose = 19'($urandom);
         end
         send_query(top, choose, binomial_of(top, choose));
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d queries, %0d answers checked: table extremes, r below zero and above n,",
               queries_sent, answers_seen);
      $display("random gaps on both sides, a long output stall and one full drain");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // answer side: random hold-offs, one long stall to back up the pipe
   initial begin
      answer_type want;
      int hold;
      @(negedge reset);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (answers_seen % 250 < 50) begin
            hold = 0;
         end
         if (answers_seen == StallAt) begin
            hold = 400;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected answer beat: coefficient %0d range_error %0b",
                        rsp_coefficient, rsp_range_error);
            end
         end else begin
            want = pending_answers.pop_front();
            if (rsp_coefficient !== want.coefficient
                || rsp_range_error !== want.range_error) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("answer %0d: expected coefficient %0d range_error %0b, got %0d %0b",
                           answers_seen, want.coefficient, want.range_error,
                           rsp_coefficient, rsp_range_error);
               end
            end
         end
         answers_seen++;
         @(posedge clock);
      end
   end
endmodule
